// File: rtl/core/alle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_pkg
// Shared types and constants of the array linked list engine.
// ----------------------------------------------------------------------------
package alle_pkg;

  localparam int IDX_W  = 8;
  localparam int DATA_W = 32;

  localparam logic [IDX_W-1:0] NULL_IDX = 8'hFF;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_SEARCH = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_POS   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RD_FREE,
    OP_ALLOC,
    OP_RD_HEAD,
    OP_STEP,
    OP_LINK_TAIL,
    OP_HEAD_NEW,
    OP_SPLICE,
    OP_RM_HEAD,
    OP_RD_LINKQ,
    OP_BYPASS,
    OP_FREE,
    OP_HIT,
    OP_PUBLISH
  } alle_op_t;

  typedef struct packed {
    alle_op_t   op;
    logic       st_we;
    logic [1:0] st;
  } alle_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       pos_zero;
    logic       pos_one;
    logic       ins_ok;
    logic       rd_ok;
    logic       count_zero;
    logic       rem_zero;
    logic       key_hit;
  } alle_sts_t;

endpackage

// File: rtl/core/alle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_if
// Request and result channels: valid/ready transfer with payload.
// ----------------------------------------------------------------------------
interface alle_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] elem_key;
  logic [31:0]        elem_payload;
  logic [7:0]         position;

  modport source (output valid, cmd, elem_key, elem_payload, position, input ready);
  modport sink   (input valid, cmd, elem_key, elem_payload, position, output ready);
endinterface

interface alle_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] found_key;
  logic [31:0]        found_payload;
  logic [7:0]         entry_count;

  modport source (output valid, status, found_key, found_payload, entry_count,
                  input ready);
  modport sink   (input valid, status, found_key, found_payload, entry_count,
                  output ready);
endinterface

// File: rtl/core/alle_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_dp
// Node memories, list pointers, walk cursor and result registers.
// ----------------------------------------------------------------------------
module alle_dp import alle_pkg::*; #(
  parameter int NODE_COUNT = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  alle_cmd_t          cmd,
  output alle_sts_t          sts,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_elem_key,
  input  logic [31:0]        in_elem_payload,
  input  logic [7:0]         in_position,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_found_key,
  output logic [31:0]        out_found_payload,
  output logic [7:0]         out_entry_count
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam logic [IDX_W:0]   NC9 = (IDX_W+1)'(NODE_COUNT);
  localparam logic [IDX_W-1:0] NC8 = IDX_W'(NODE_COUNT);
  localparam logic [AW-1:0]    LAST_A = AW'(NODE_COUNT - 1);

  logic [DATA_W-1:0] key_mem  [NODE_COUNT];
  logic [DATA_W-1:0] pay_mem  [NODE_COUNT];
  logic [IDX_W-1:0]  link_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] lv_r;

  logic [2:0]               cmd_r;
  logic signed [DATA_W-1:0] key_r;
  logic [DATA_W-1:0]        pay_r;
  logic [IDX_W-1:0]         pos_r;
  logic [IDX_W-1:0]         head_r, free_r, count_r;
  logic [IDX_W-1:0]         cur_r, rem_r, p_r;
  logic [IDX_W-1:0]         link_q;
  logic [DATA_W-1:0]        key_q, pay_q;
  logic [1:0]               st_r;
  logic [DATA_W-1:0]        fkey_r, fpay_r;

  logic                     rd_en, lk_we, kp_we;
  logic [IDX_W-1:0]         rd_idx, lk_idx, lk_dat, rem_init, rd_dflt;
  logic [AW-1:0]            rd_a, lk_a, kp_a;

  always_comb begin
    rd_en  = 1'b0;
    rd_idx = head_r;
    lk_we  = 1'b0;
    lk_idx = p_r;
    lk_dat = NULL_IDX;
    kp_we  = 1'b0;
    unique case (cmd.op)
      OP_RD_FREE:   begin rd_en = 1'b1; rd_idx = free_r; end
      OP_ALLOC:     begin kp_we = 1'b1; lk_we = 1'b1; end
      OP_RD_HEAD:   begin rd_en = 1'b1; rd_idx = head_r; end
      OP_STEP:      begin rd_en = 1'b1; rd_idx = link_q; end
      OP_RD_LINKQ:  begin rd_en = 1'b1; rd_idx = link_q; end
      OP_LINK_TAIL: begin lk_we = 1'b1; lk_idx = cur_r; lk_dat = p_r; end
      OP_HEAD_NEW:  begin lk_we = 1'b1; lk_dat = head_r; end
      OP_SPLICE:    begin lk_we = 1'b1; lk_dat = link_q; end
      OP_BYPASS:    begin lk_we = 1'b1; lk_idx = cur_r; lk_dat = link_q; end
      OP_FREE:      begin lk_we = 1'b1; lk_dat = free_r; end
      default: ;
    endcase
  end

  assign rd_a    = rd_idx[AW-1:0];
  assign lk_a    = lk_idx[AW-1:0];
  assign kp_a    = p_r[AW-1:0];
  assign rd_dflt = (rd_a == LAST_A) ? NULL_IDX : IDX_W'(rd_a) + 8'd1;

  always_ff @(posedge clk) begin
    if (kp_we) begin
      key_mem[kp_a] <= key_r;
      pay_mem[kp_a] <= pay_r;
    end
    if (lk_we) link_mem[lk_a] <= lk_dat;
    if (rd_en) begin
      key_q  <= key_mem[rd_a];
      pay_q  <= pay_mem[rd_a];
      link_q <= lv_r[rd_a] ? link_mem[rd_a] : rd_dflt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= '0;
    end else if (lk_we) begin
      lv_r[lk_a] <= 1'b1;
    end
  end

  always_comb begin
    unique case (cmd_r)
      CMD_APPEND, CMD_SEARCH: rem_init = count_r - 8'd1;
      CMD_INSERT, CMD_REMOVE: rem_init = pos_r - 8'd2;
      default:                rem_init = pos_r - 8'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= NULL_IDX;
      free_r  <= '0;
      count_r <= '0;
    end else begin
      unique case (cmd.op)
        OP_ALLOC:     free_r  <= link_q;
        OP_LINK_TAIL: count_r <= count_r + 8'd1;
        OP_HEAD_NEW:  begin head_r <= p_r; count_r <= count_r + 8'd1; end
        OP_RM_HEAD:   head_r  <= link_q;
        OP_FREE:      begin free_r <= p_r; count_r <= count_r - 8'd1; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        cmd_r  <= in_cmd;
        key_r  <= in_elem_key;
        pay_r  <= in_elem_payload;
        pos_r  <= in_position;
        fkey_r <= '0;
        fpay_r <= '0;
      end
      OP_RD_FREE:  p_r <= free_r;
      OP_RD_HEAD:  begin cur_r <= head_r; rem_r <= rem_init; end
      OP_STEP:     begin cur_r <= link_q; rem_r <= rem_r - 8'd1; end
      OP_RM_HEAD:  begin p_r <= cur_r; fkey_r <= key_q; fpay_r <= pay_q; end
      OP_RD_LINKQ: p_r <= link_q;
      OP_BYPASS, OP_HIT: begin fkey_r <= key_q; fpay_r <= pay_q; end
      OP_PUBLISH: begin
        out_status        <= st_r;
        out_found_key     <= fkey_r;
        out_found_payload <= fpay_r;
        out_entry_count   <= count_r;
      end
      default: ;
    endcase
    if (cmd.op == OP_LOAD) st_r <= ST_OK;
    else if (cmd.st_we) st_r <= cmd.st;
  end

  assign sts.cmd        = cmd_r;
  assign sts.full       = ((IDX_W+1)'(count_r) >= NC9) || (free_r >= NC8);
  assign sts.pos_zero   = (pos_r == '0);
  assign sts.pos_one    = (pos_r == 8'd1);
  assign sts.ins_ok     = ((IDX_W+1)'(pos_r) <= (IDX_W+1)'(count_r) + 9'd1);
  assign sts.rd_ok      = (pos_r <= count_r);
  assign sts.count_zero = (count_r == '0);
  assign sts.rem_zero   = (rem_r == '0);
  assign sts.key_hit    = (key_q == key_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (IDX_W+1)'(count_r) <= NC9)
    else $error("element count beyond node count");
  // the count lags the free pointer by one node while an allocation is linked in
  a_free_avail: assert property (@(posedge clk) disable iff (!rst_n)
    (((IDX_W+1)'(count_r) + 9'd1) < NC9) |-> (free_r < NC8))
    else $error("free chain empty while list not full");
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == NULL_IDX))
    else $error("empty list with a head node");

endmodule

// File: rtl/core/alle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_ctrl
// Request sequencer: decodes, walks the list and hands off the result.
// ----------------------------------------------------------------------------
module alle_ctrl import alle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  alle_sts_t sts,
  output alle_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ALLOC, S_HEAD, S_WALK, S_SPLICE, S_LINK, S_HEADNEW,
    S_RMHEAD, S_RDP, S_BYPASS, S_FREE, S_SRCH, S_HIT, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   pub_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign pub_ok    = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    cmd.st_we = 1'b0;
    cmd.st    = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin cmd.op = OP_LOAD; state_nxt = S_DISPATCH; end
      end
      S_DISPATCH: begin
        state_nxt = S_DONE;
        priority case (sts.cmd)
          CMD_APPEND, CMD_INSERT: begin
            if (sts.full) begin
              cmd.st_we = 1'b1; cmd.st = ST_FULL;
            end else if (sts.cmd == CMD_INSERT && (sts.pos_zero || !sts.ins_ok)) begin
              cmd.st_we = 1'b1; cmd.st = ST_BAD_POS;
            end else begin
              cmd.op = OP_RD_FREE; state_nxt = S_ALLOC;
            end
          end
          CMD_REMOVE, CMD_READ: begin
            if (sts.pos_zero || !sts.rd_ok) begin
              cmd.st_we = 1'b1; cmd.st = ST_BAD_POS;
            end else begin
              cmd.op = OP_RD_HEAD;
              state_nxt = (sts.cmd == CMD_REMOVE && sts.pos_one) ? S_RMHEAD : S_WALK;
            end
          end
          CMD_SEARCH: begin
            if (sts.count_zero) begin
              cmd.st_we = 1'b1; cmd.st = ST_NOT_FOUND;
            end else begin
              cmd.op = OP_RD_HEAD; state_nxt = S_SRCH;
            end
          end
          default: ;
        endcase
      end
      S_ALLOC: begin
        cmd.op = OP_ALLOC;
        if (sts.cmd == CMD_APPEND) state_nxt = sts.count_zero ? S_HEADNEW : S_HEAD;
        else state_nxt = sts.pos_one ? S_HEADNEW : S_HEAD;
      end
      S_HEAD: begin cmd.op = OP_RD_HEAD; state_nxt = S_WALK; end
      S_WALK: begin
        if (!sts.rem_zero) begin
          cmd.op = OP_STEP;
        end else begin
          priority case (sts.cmd)
            CMD_APPEND: state_nxt = S_LINK;
            CMD_INSERT: state_nxt = S_SPLICE;
            CMD_REMOVE: state_nxt = S_RDP;
            default:    state_nxt = S_HIT;
          endcase
        end
      end
      S_SPLICE:  begin cmd.op = OP_SPLICE;    state_nxt = S_LINK;   end
      S_LINK:    begin cmd.op = OP_LINK_TAIL; state_nxt = S_DONE;   end
      S_HEADNEW: begin cmd.op = OP_HEAD_NEW;  state_nxt = S_DONE;   end
      S_RMHEAD:  begin cmd.op = OP_RM_HEAD;   state_nxt = S_FREE;   end
      S_RDP:     begin cmd.op = OP_RD_LINKQ;  state_nxt = S_BYPASS; end
      S_BYPASS:  begin cmd.op = OP_BYPASS;    state_nxt = S_FREE;   end
      S_FREE:    begin cmd.op = OP_FREE;      state_nxt = S_DONE;   end
      S_HIT:     begin cmd.op = OP_HIT;       state_nxt = S_DONE;   end
      S_SRCH: begin
        if (sts.key_hit) begin
          cmd.op = OP_HIT; state_nxt = S_DONE;
        end else if (sts.rem_zero) begin
          cmd.st_we = 1'b1; cmd.st = ST_NOT_FOUND; state_nxt = S_DONE;
        end else begin
          cmd.op = OP_STEP;
        end
      end
      S_DONE: begin
        if (pub_ok) begin cmd.op = OP_PUBLISH; state_nxt = S_IDLE; end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (state_r == S_DONE && pub_ok) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/array_linked_list_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_engine_core
// Linked list with free chain in a fixed node memory; one request at a time.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result. A request walks one
// node per cycle: append walks to the tail (count-1 nodes), insert and
// remove to the node before the position, read to the position and search
// until the first match, at most count-1 nodes. The link walk goes through
// the single-port node memory. A finished result is held in an output
// register, so the next request is taken while it waits. No clearing pass
// after reset.
module array_linked_list_engine_core import alle_pkg::*; #(
  parameter int NODE_COUNT = 128
) (
  input logic       clk,
  input logic       rst_n,
  alle_in_if.sink   in_ch,
  alle_out_if.source out_ch
);

  alle_cmd_t cmd;
  alle_sts_t sts;

  alle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  alle_dp #(.NODE_COUNT(NODE_COUNT)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_cmd            (in_ch.cmd),
    .in_elem_key       (in_ch.elem_key),
    .in_elem_payload   (in_ch.elem_payload),
    .in_position       (in_ch.position),
    .out_status        (out_ch.status),
    .out_found_key     (out_ch.found_key),
    .out_found_payload (out_ch.found_payload),
    .out_entry_count   (out_ch.entry_count)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the array linked list engine. A short stimulus table
// covers empty, full-range and bad-position cases. Random requests follow,
// swinging the list between empty and full. Every result transfer is checked
// against the table's expected values or a behavioural list model, under
// random idling on both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import alle_pkg::*;

  localparam int NODES     = 128;
  localparam int N_RANDOM  = 1525;
  localparam int WDOG_MAX  = 6000;
  localparam int HOLD_LEN  = 1500;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] fkey;
    logic [31:0] fpay;
    logic [7:0]  cnt;
  } result_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] key;
    logic [31:0] pay;
    logic [7:0]  pos;
    logic        typed;
    logic [1:0]  st;
    logic [7:0]  cnt;
  } row_t;

  logic clk;
  logic rst_n;

  alle_in_if  in_ch ();
  alle_out_if out_ch ();

  array_linked_list_engine_core #(.NODE_COUNT(NODES)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // list model
  logic [31:0] m_key  [NODES];
  logic [31:0] m_pay  [NODES];
  logic [7:0]  m_link [NODES];
  logic [7:0]  m_head;
  logic [7:0]  m_free;
  int          m_cnt;

  result_t pending_q[$];
  int      errors;
  int      idle_cycles;
  bit      hold_req;
  int      burst_left;

  function automatic logic [7:0] succ(logic [7:0] idx);
    return (idx >= NODES) ? NULL_IDX : m_link[idx];
  endfunction

  function automatic logic [7:0] node_at(int pos);
    logic [7:0] q;
    q = m_head;
    for (int i = 1; i < pos && q < NODES; i++) q = succ(q);
    return q;
  endfunction

  function automatic void list_reset();
    for (int i = 0; i < NODES; i++) m_link[i] = (i + 1 < NODES) ? 8'(i + 1) : NULL_IDX;
    m_head = NULL_IDX;
    m_free = 8'd0;
    m_cnt  = 0;
  endfunction

  function automatic result_t list_apply(logic [2:0] cmd, logic [31:0] key,
                                         logic [31:0] pay, logic [7:0] pos);
    result_t r;
    logic [7:0] p, q;
    r = '0;
    case (cmd)
      CMD_APPEND, CMD_INSERT: begin
        if (m_cnt >= NODES || m_free >= NODES) begin
          r.st = ST_FULL;
        end else if (cmd == CMD_INSERT && (pos < 1 || pos > m_cnt + 1)) begin
          r.st = ST_BAD_POS;
        end else begin
          p = m_free;
          m_free = succ(p);
          m_key[p] = key;
          m_pay[p] = pay;
          m_link[p] = NULL_IDX;
          if (cmd == CMD_APPEND) begin
            if (m_cnt == 0 || m_head >= NODES) m_head = p;
            else begin
              q = node_at(m_cnt);
              if (q < NODES) m_link[q] = p;
            end
          end else if (pos == 1) begin
            m_link[p] = m_head;
            m_head = p;
          end else begin
            q = node_at(pos - 1);
            m_link[p] = succ(q);
            if (q < NODES) m_link[q] = p;
          end
          m_cnt++;
        end
      end
      CMD_REMOVE: begin
        if (pos < 1 || pos > m_cnt) begin
          r.st = ST_BAD_POS;
        end else begin
          if (pos == 1) begin
            p = m_head;
            m_head = succ(p);
          end else begin
            q = node_at(pos - 1);
            p = succ(q);
            if (q < NODES) m_link[q] = succ(p);
          end
          if (p < NODES) begin
            r.fkey = m_key[p];
            r.fpay = m_pay[p];
            m_link[p] = m_free;
            m_free = p;
          end
          m_cnt--;
        end
      end
      CMD_SEARCH: begin
        r.st = ST_NOT_FOUND;
        q = m_head;
        for (int i = 0; i < m_cnt && q < NODES; i++) begin
          if (m_key[q] == key) begin
            r.st = ST_OK;
            r.fkey = m_key[q];
            r.fpay = m_pay[q];
            break;
          end
          q = succ(q);
        end
      end
      CMD_READ: begin
        if (pos < 1 || pos > m_cnt) r.st = ST_BAD_POS;
        else begin
          q = node_at(pos);
          if (q < NODES) begin
            r.fkey = m_key[q];
            r.fpay = m_pay[q];
          end
        end
      end
      default: ;
    endcase
    r.cnt = 8'(m_cnt);
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send(row_t rw);
    result_t r;
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.cmd          = rw.cmd;
    in_ch.elem_key     = rw.key;
    in_ch.elem_payload = rw.pay;
    in_ch.position     = rw.pos;
    in_ch.valid        = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = list_apply(rw.cmd, rw.key, rw.pay, rw.pos);
    if (rw.typed) begin
      r = '0;
      r.st  = rw.st;
      r.cnt = rw.cnt;
    end
    pending_q.push_back(r);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    return ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
  endfunction

  function automatic row_t rand_row(bit grow);
    row_t rw;
    int sel;
    rw = '0;
    rw.key = pick_key();
    rw.pay = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 4) rw.cmd = 3'($urandom_range(5, 7));
    else if (sel < (grow ? 40 : 14)) rw.cmd = CMD_APPEND;
    else if (sel < (grow ? 70 : 30)) rw.cmd = CMD_INSERT;
    else if (sel < (grow ? 78 : 65)) rw.cmd = CMD_REMOVE;
    else if (sel < 88) rw.cmd = CMD_SEARCH;
    else rw.cmd = CMD_READ;
    if ($urandom_range(0, 9) < 8) rw.pos = 8'($urandom_range(1, m_cnt + 1));
    else rw.pos = 8'($urandom_range(0, 255));
    if (rw.cmd == CMD_SEARCH && m_cnt > 0 && $urandom_range(0, 2) != 0)
      rw.key = m_key[node_at($urandom_range(1, m_cnt))];
    return rw;
  endfunction

  row_t dir_tbl[$] = '{
    '{CMD_READ,   32'd0,          32'd0,          8'd1,   1'b1, ST_BAD_POS,   8'd0},
    '{CMD_REMOVE, 32'd0,          32'd0,          8'd1,   1'b1, ST_BAD_POS,   8'd0},
    '{CMD_SEARCH, 32'd0,          32'd0,          8'd0,   1'b1, ST_NOT_FOUND, 8'd0},
    '{CMD_APPEND, 32'h8000_0000,  32'h0000_0000,  8'd0,   1'b1, ST_OK,        8'd1},
    '{CMD_APPEND, 32'h7FFF_FFFF,  32'hFFFF_FFFF,  8'd255, 1'b1, ST_OK,        8'd2},
    '{CMD_INSERT, 32'd9,          32'd9,          8'd0,   1'b1, ST_BAD_POS,   8'd2},
    '{CMD_INSERT, 32'd9,          32'd9,          8'd4,   1'b1, ST_BAD_POS,   8'd2},
    '{CMD_INSERT, 32'hFFFF_FFFF,  32'd1,          8'd1,   1'b1, ST_OK,        8'd3},
    '{CMD_INSERT, 32'd5,          32'hA5A5_5A5A,  8'd4,   1'b1, ST_OK,        8'd4},
    '{CMD_INSERT, 32'd6,          32'h5A5A_A5A5,  8'd2,   1'b1, ST_OK,        8'd5},
    '{CMD_READ,   32'd0,          32'd0,          8'd1,   1'b0, ST_OK,        8'd0},
    '{CMD_READ,   32'd0,          32'd0,          8'd5,   1'b0, ST_OK,        8'd0},
    '{CMD_READ,   32'd0,          32'd0,          8'd6,   1'b1, ST_BAD_POS,   8'd5},
    '{CMD_SEARCH, 32'h7FFF_FFFF,  32'd0,          8'd0,   1'b0, ST_OK,        8'd0},
    '{CMD_SEARCH, 32'd12345,      32'd0,          8'd0,   1'b1, ST_NOT_FOUND, 8'd5},
    '{CMD_REMOVE, 32'd0,          32'd0,          8'd3,   1'b0, ST_OK,        8'd0},
    '{CMD_REMOVE, 32'd0,          32'd0,          8'd255, 1'b1, ST_BAD_POS,   8'd4},
    '{CMD_REMOVE, 32'd0,          32'd0,          8'd1,   1'b0, ST_OK,        8'd0},
    '{3'd5,       32'hFFFF_FFFF,  32'hFFFF_FFFF,  8'd255, 1'b1, ST_OK,        8'd3},
    '{3'd6,       32'd1,          32'd1,          8'd1,   1'b1, ST_OK,        8'd3},
    '{3'd7,       32'd0,          32'd0,          8'd0,   1'b1, ST_OK,        8'd3},
    '{CMD_APPEND, 32'd77,         32'd78,         8'd0,   1'b0, ST_OK,        8'd0},
    '{CMD_READ,   32'd0,          32'd0,          8'd4,   1'b0, ST_OK,        8'd0},
    '{CMD_SEARCH, 32'hFFFF_FFFF,  32'd0,          8'd0,   1'b0, ST_OK,        8'd0}
  };

  initial begin
    bit grow;
    errors       = 0;
    hold_req     = 1'b0;
    burst_left   = 0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = '0;
    in_ch.elem_key = '0;
    in_ch.elem_payload = '0;
    in_ch.position = '0;
    list_reset();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    foreach (dir_tbl[i]) send(dir_tbl[i]);
    grow = 1'b1;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (m_cnt >= NODES) grow = 1'b0;
      else if (m_cnt == 0) grow = 1'b1;
      else if ($urandom_range(0, 299) == 0) grow = ~grow;
      if (n == 800) hold_req = 1'b1;
      send(rand_row(grow));
    end
    in_ch.valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // result side stall pattern
  initial begin
    int mode;
    int hold;
    out_ch.ready = 1'b0;
    mode = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold == 0) begin
        hold = HOLD_LEN;
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (hold > 0) begin
        hold--;
        out_ch.ready = 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = ($urandom_range(0, 3) != 0);
          default: out_ch.ready = ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_ch.status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_ch.status);
          errors++;
        end
        if (out_ch.found_key !== want.fkey) begin
          $error("found_key: expected %h, got %h", want.fkey, out_ch.found_key);
          errors++;
        end
        if (out_ch.found_payload !== want.fpay) begin
          $error("found_payload: expected %h, got %h", want.fpay, out_ch.found_payload);
          errors++;
        end
        if (out_ch.entry_count !== want.cnt) begin
          $error("entry_count: expected %0d, got %0d", want.cnt, out_ch.entry_count);
          errors++;
        end
      end
    end
  end

  // watchdog on transfer activity
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WDOG_MAX) begin
      $display("TEST FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

endmodule

// File: files.f
rtl/core/alle_pkg.sv
rtl/core/alle_if.sv
rtl/core/alle_dp.sv
rtl/core/alle_ctrl.sv
rtl/core/array_linked_list_engine_core.sv
tb/sv/tb_top.sv
